// ===== sv/isrr_pkg.sv =====
// ----------------------------------------------------------------------------
// isrr_pkg
// shared widths and types for the rounded integer square root pipeline
// ----------------------------------------------------------------------------
package isrr_pkg;

    // width of the operand field on the input channel
    localparam int OPND_FIELD_BITS = 32;

    // width of the root field on the output channel
    localparam int ROOT_BITS = 17;

    typedef logic [ROOT_BITS-1:0] t_root;

endpackage

// ===== sv/isrr_stage.sv =====
// ----------------------------------------------------------------------------
// isrr_stage
// one restoring digit step: retires two operand bits, yields one root bit
// ----------------------------------------------------------------------------
module isrr_stage #(
    parameter int ROOT_W = 16,
    parameter int REM_W  = 18,
    parameter int OPND_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [ROOT_W-1:0] i_root,
    input  logic [OPND_W-1:0] i_opnd,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [REM_W-1:0]  o_rem,
    output logic [ROOT_W-1:0] o_root,
    output logic [OPND_W-1:0] o_opnd
);

    logic              r_valid;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [OPND_W-1:0] r_opnd;

    logic [REM_W-1:0]  n_rem;
    logic [ROOT_W-1:0] n_root;
    logic [OPND_W-1:0] n_opnd;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              fits;

    // stage can take a beat when empty or when its beat moves on
    assign o_ready = !r_valid || i_ready;

    always_comb begin
        rem_sh = {i_rem[REM_W-3:0], i_opnd[OPND_W-1 -: 2]};
        trial  = {i_root, 2'b01};
        fits   = (rem_sh >= trial);
        n_rem  = fits ? (rem_sh - trial) : rem_sh;
        n_root = {i_root[ROOT_W-2:0], fits};
        n_opnd = {i_opnd[OPND_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_opnd <= n_opnd;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_opnd  = r_opnd;

    // residue never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_rem <= {1'b0, r_root, 1'b0}))
        else $error("residue above twice the partial root");

    // a held beat keeps its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_rem) && $stable(r_root)))
        else $error("stalled stage lost or changed its beat");

    // reset empties the stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_valid)
        else $error("stage holds a beat after reset");

endmodule

// ===== sv/isrr_round.sv =====
// ----------------------------------------------------------------------------
// isrr_round
// rounding correction and output register
// ----------------------------------------------------------------------------
module isrr_round #(
    parameter int ROOT_W = 16,
    parameter int REM_W  = 18
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_trunc,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [ROOT_W-1:0] i_root,
    output logic              o_valid,
    input  logic              i_stall,
    output isrr_pkg::t_root   o_root
);

    import isrr_pkg::*;

    logic          r_valid;
    t_root         r_root;
    t_root         n_root;
    logic          round_up;
    logic [ROOT_W:0] sum;

    assign o_ready = !r_valid || !i_stall;

    always_comb begin
        // round up when operand - root^2 exceeds root
        round_up = !i_trunc && (i_rem > {2'b00, i_root});
        sum      = {1'b0, i_root} + {{ROOT_W{1'b0}}, round_up};
        n_root   = ROOT_BITS'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_root <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_root  = r_root;

endmodule

// ===== sv/integer_square_root_rounded.sv =====
// ----------------------------------------------------------------------------
// integer_square_root_rounded
// pipelined unsigned integer square root, rounded to nearest or truncated
// ----------------------------------------------------------------------------
// Takes one unsigned operand per beat and returns one root per beat, in order.
// The root is built by the binary restoring digit-by-digit method, one
// register stage per root bit (two operand bits per stage), followed by an
// output register that applies the rounding correction. A new operand can be
// accepted on every clock while o_stall is low. The effective operand width
// is W = min(OPERAND_BITS, 32), i.e. 32 bits for the default operand.
// Stall on the output backs up stage by stage, so bubbles inside the pipe are
// filled before the input is stalled. Writing 1 to the config bit selects the
// floor of the square root; the reset value 0 rounds to the nearest integer,
// so a full-scale operand yields 65536. Operand bits at and above
// OPERAND_BITS are ignored. Change the config bit only while the pipe is empty.
// ----------------------------------------------------------------------------
module integer_square_root_rounded #(
    parameter int OPERAND_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config
    input  logic                                 i_cfg_wr_en,
    input  logic                                 i_cfg_wr_data,
    // operand channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [isrr_pkg::OPND_FIELD_BITS-1:0] i_operand,
    // root channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output isrr_pkg::t_root                      o_square_root
);

    import isrr_pkg::*;

    // effective operand width, number of digit stages and datapath widths
    localparam int OPND_W = (OPERAND_BITS > OPND_FIELD_BITS) ? OPND_FIELD_BITS
                                                             : OPERAND_BITS;
    localparam int N_DIG  = (OPND_W + 1) / 2;
    localparam int PAD_W  = 2 * N_DIG;
    localparam int REM_W  = N_DIG + 2;

    // truncate mode bit
    logic r_trunc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trunc <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_trunc <= i_cfg_wr_data;
        end
    end

    // stage links: index k feeds digit stage k, index N_DIG feeds rounding
    logic             lnk_valid [0:N_DIG];
    logic             lnk_ready [0:N_DIG];
    logic [REM_W-1:0] lnk_rem   [0:N_DIG];
    logic [N_DIG-1:0] lnk_root  [0:N_DIG];
    logic [PAD_W-1:0] lnk_opnd  [0:N_DIG];

    // entry: empty residue and root, operand masked and padded to even width
    assign lnk_valid[0] = i_valid;
    assign lnk_rem[0]   = '0;
    assign lnk_root[0]  = '0;
    assign lnk_opnd[0]  = PAD_W'(i_operand[OPND_W-1:0]);
    assign o_stall      = !lnk_ready[0];

    for (genvar k = 0; k < N_DIG; k++) begin : g_dig
        isrr_stage #(
            .ROOT_W (N_DIG),
            .REM_W  (REM_W),
            .OPND_W (PAD_W)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (lnk_valid[k]),
            .o_ready (lnk_ready[k]),
            .i_rem   (lnk_rem[k]),
            .i_root  (lnk_root[k]),
            .i_opnd  (lnk_opnd[k]),
            .o_valid (lnk_valid[k+1]),
            .i_ready (lnk_ready[k+1]),
            .o_rem   (lnk_rem[k+1]),
            .o_root  (lnk_root[k+1]),
            .o_opnd  (lnk_opnd[k+1])
        );
    end

    // operand bits are fully consumed after the last digit stage
    isrr_round #(
        .ROOT_W (N_DIG),
        .REM_W  (REM_W)
    ) u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_trunc (r_trunc),
        .i_valid (lnk_valid[N_DIG]),
        .o_ready (lnk_ready[N_DIG]),
        .i_rem   (lnk_rem[N_DIG]),
        .i_root  (lnk_root[N_DIG]),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_root  (o_square_root)
    );

endmodule
